// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the shadow projector.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define PSVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define PSVP_ASSERT_IMP(lbl, ante, cons, msg) \
  `PSVP_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/psvp_pkg.sv -----
// Shared types and constants of the planar shadow vertex projector.
// No dependencies; used by the top level, the checker and the testbench.
package psvp_pkg;

  localparam int COORD_W    = 32;
  localparam int DIR_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COORD_W > DIR_W) ? COORD_W : DIR_W;

  localparam int MARGIN = 655;
  localparam int LIFT   = 197;

  localparam longint OFF_Y_RAW = -64'sd65536000;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
  localparam logic [COORD_W-1:0] OFF_Y =
    COORD_W'((OFF_Y_RAW < COORD_MIN) ? COORD_MIN : OFF_Y_RAW);

  localparam logic [DIR_W-1:0] DIR_Y_RESET = DIR_W'(65536);

  // input regs, magnitude, first divider, product, second divider, five tail stages
  localparam int LATENCY = 2 + (COORD_W + 1) + 1 + (2 * DIR_W - 2) + 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_X     = 3'd0,
    REG_DIR_Y     = 3'd1,
    REG_DIR_Z     = 3'd2,
    REG_PLANE_H   = 3'd3,
    REG_BOX_MIN_X = 3'd4,
    REG_BOX_MAX_X = 3'd5,
    REG_BOX_MIN_Z = 3'd6,
    REG_BOX_MAX_Z = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] shadow_x;
    logic signed [COORD_W-1:0] shadow_y;
    logic signed [COORD_W-1:0] shadow_z;
    logic                      on_receiver;
  } shadow_t;

endpackage

// ----- rtl/psvp_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Unsigned lanes share one divisor; depends on nothing outside this file.
module psvp_div_pipe #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 18,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]             den,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [LANES-1:0][NUM_W-1:0]  out_quot,
  output logic [LANES-1:0][DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0]            out_side
);

  logic [NUM_W-1:0]                valid_r;
  logic [LANES-1:0][NUM_W-1:0]     acc_r  [NUM_W];
  logic [LANES-1:0][DEN_W-1:0]     rem_r  [NUM_W];
  logic [SIDE_W-1:0]               side_r [NUM_W];

  wire  [LANES-1:0][NUM_W-1:0]     acc_nxt [NUM_W];
  wire  [LANES-1:0][DEN_W-1:0]     rem_nxt [NUM_W];

  genvar s, l;
  generate
    for (s = 0; s < NUM_W; s++) begin : g_step
      wire [LANES-1:0][NUM_W-1:0] acc_cur;
      wire [LANES-1:0][DEN_W-1:0] rem_cur;
      if (s == 0) begin : g_head
        assign acc_cur = in_num;
        assign rem_cur = '0;
      end else begin : g_body
        assign acc_cur = acc_r[s-1];
        assign rem_cur = rem_r[s-1];
      end
      for (l = 0; l < LANES; l++) begin : g_lane
        wire [DEN_W:0] trial = {rem_cur[l], acc_cur[l][NUM_W-1]};
        wire           fits  = (trial >= {1'b0, den});
        wire [DEN_W:0] diff  = trial - {1'b0, den};
        assign rem_nxt[s][l] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign acc_nxt[s][l] = {acc_cur[l][NUM_W-2:0], fits};
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[NUM_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int i = 0; i < NUM_W; i++) begin
      acc_r[i] <= acc_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
    for (int i = 1; i < NUM_W; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  assign out_valid = valid_r[NUM_W-1];
  assign out_quot  = acc_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ----- rtl/planar_shadow_vertex_projector.sv -----
// An accepted vertex passes stage 0, stage 1, both dividers, the product register and the tail stages.
// Throughput: one vertex per cycle while busy is low.
// Depth is set by two bit-serial divider pipelines (33 and 34 stages) on |light_dir_y|.
// Reset (synchronous, active low) empties the pipeline, restores direction (0,1,0),
// clears plane and box, and holds busy high for the first cycle.
// Results are a one-cycle strobe; the receiver cannot stall.
module planar_shadow_vertex_projector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  psvp_pkg::vertex_t                 in_vertex,
  output logic                              out_valid,
  output psvp_pkg::shadow_t                 out_shadow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psvp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psvp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = psvp_pkg::COORD_W;
  localparam int DW = psvp_pkg::DIR_W;
  localparam int QW = CW + 1;
  localparam int RW = DW - 1;
  localparam int PW = 2 * DW - 2;
  localparam int TW = QW + DW;
  localparam int OW = TW + 2;
  localparam int S1_SIDE_W = 2 * CW + 1;
  localparam int S2_SIDE_W = 2 * CW + QW + 1;

  localparam logic [OW-1:0] PX_MAX = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [OW-1:0] PX_MIN = {{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic [CW-1:0] sat_coord(input logic [OW-1:0] v);
    logic [CW-1:0] res;
    if ($signed(v) > $signed(PX_MAX)) begin
      res = PX_MAX[CW-1:0];
    end else if ($signed(v) < $signed(PX_MIN)) begin
      res = PX_MIN[CW-1:0];
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [DW-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [CW-1:0] plane_h_r, box_min_x_r, box_max_x_r, box_min_z_r, box_max_z_r;
  logic          busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r     <= '0;
      dir_y_r     <= psvp_pkg::DIR_Y_RESET;
      dir_z_r     <= '0;
      plane_h_r   <= '0;
      box_min_x_r <= '0;
      box_max_x_r <= '0;
      box_min_z_r <= '0;
      box_max_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (psvp_pkg::cfg_reg_t'(cfg_index))
        psvp_pkg::REG_DIR_X:     dir_x_r     <= cfg_data[DW-1:0];
        psvp_pkg::REG_DIR_Y:     dir_y_r     <= cfg_data[DW-1:0];
        psvp_pkg::REG_DIR_Z:     dir_z_r     <= cfg_data[DW-1:0];
        psvp_pkg::REG_PLANE_H:   plane_h_r   <= cfg_data[CW-1:0];
        psvp_pkg::REG_BOX_MIN_X: box_min_x_r <= cfg_data[CW-1:0];
        psvp_pkg::REG_BOX_MAX_X: box_max_x_r <= cfg_data[CW-1:0];
        psvp_pkg::REG_BOX_MIN_Z: box_min_z_r <= cfg_data[CW-1:0];
        psvp_pkg::REG_BOX_MAX_Z: box_max_z_r <= cfg_data[CW-1:0];
      endcase
    end
  end

  // values derived from configuration, refreshed every cycle
  logic [DW-1:0] dx_mag_r, dy_mag_r, dz_mag_r;
  logic          dx_neg_r, dy_neg_r, dz_neg_r, dy_zero_r;
  logic [OW-1:0] lo_x_r, hi_x_r, lo_z_r, hi_z_r;
  logic [CW-1:0] lift_y_r;
  logic [CW:0]   lift_sum;

  assign lift_sum = {plane_h_r[CW-1], plane_h_r} + (CW+1)'(psvp_pkg::LIFT);

  always_ff @(posedge clk) begin
    dx_mag_r  <= dir_x_r[DW-1] ? (~dir_x_r + DW'(1)) : dir_x_r;
    dy_mag_r  <= dir_y_r[DW-1] ? (~dir_y_r + DW'(1)) : dir_y_r;
    dz_mag_r  <= dir_z_r[DW-1] ? (~dir_z_r + DW'(1)) : dir_z_r;
    dx_neg_r  <= dir_x_r[DW-1];
    dy_neg_r  <= dir_y_r[DW-1];
    dz_neg_r  <= dir_z_r[DW-1];
    dy_zero_r <= (dir_y_r == '0);
    lo_x_r    <= {{(OW-CW){box_min_x_r[CW-1]}}, box_min_x_r} - OW'(psvp_pkg::MARGIN);
    hi_x_r    <= {{(OW-CW){box_max_x_r[CW-1]}}, box_max_x_r} + OW'(psvp_pkg::MARGIN);
    lo_z_r    <= {{(OW-CW){box_min_z_r[CW-1]}}, box_min_z_r} - OW'(psvp_pkg::MARGIN);
    hi_z_r    <= {{(OW-CW){box_max_z_r[CW-1]}}, box_max_z_r} + OW'(psvp_pkg::MARGIN);
    if (lift_sum[CW] != lift_sum[CW-1]) begin
      lift_y_r <= lift_sum[CW] ? PX_MIN[CW-1:0] : PX_MAX[CW-1:0];
    end else begin
      lift_y_r <= lift_sum[CW-1:0];
    end
  end

  // stage 0: height difference
  logic          s0_v_r;
  logic [QW-1:0] s0_diff_r;
  logic [CW-1:0] s0_x_r, s0_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_diff_r <= {plane_h_r[CW-1], plane_h_r} -
                 {in_vertex.vertex_y[CW-1], in_vertex.vertex_y};
    s0_x_r    <= in_vertex.vertex_x;
    s0_z_r    <= in_vertex.vertex_z;
  end

  // stage 1: magnitude and sign
  logic          s1_v_r, s1_dneg_r;
  logic [QW-1:0] s1_mag_r;
  logic [CW-1:0] s1_x_r, s1_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dneg_r <= s0_diff_r[QW-1];
    s1_mag_r  <= s0_diff_r[QW-1] ? (~s0_diff_r + QW'(1)) : s0_diff_r;
    s1_x_r    <= s0_x_r;
    s1_z_r    <= s0_z_r;
  end

  // first divider: |diff| / |dy|
  logic                    d1_v;
  logic [0:0][QW-1:0]      d1_quot;
  logic [0:0][DW-1:0]      d1_rem;
  logic [S1_SIDE_W-1:0]    d1_side;
  logic [CW-1:0]           d1_x, d1_z;
  logic                    d1_dneg;

  psvp_div_pipe #(
    .NUM_W  (QW),
    .DEN_W  (DW),
    .LANES  (1),
    .SIDE_W (S1_SIDE_W)
  ) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_num    (s1_mag_r),
    .den       (dy_mag_r),
    .in_side   ({s1_x_r, s1_z_r, s1_dneg_r}),
    .out_valid (d1_v),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_side  (d1_side)
  );

  assign {d1_x, d1_z, d1_dneg} = d1_side;

  // remainder products
  logic               m_v_r, m_dneg_r;
  logic [PW-1:0]      m_rx_r, m_rz_r;
  logic [QW-1:0]      m_q_r;
  logic [CW-1:0]      m_x_r, m_z_r;
  logic [RW+DW-1:0]   rx_full, rz_full;

  assign rx_full = d1_rem[0][RW-1:0] * dx_mag_r;
  assign rz_full = d1_rem[0][RW-1:0] * dz_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    m_rx_r   <= rx_full[PW-1:0];
    m_rz_r   <= rz_full[PW-1:0];
    m_q_r    <= d1_quot[0];
    m_x_r    <= d1_x;
    m_z_r    <= d1_z;
    m_dneg_r <= d1_dneg;
  end

  // second divider: r*|d| / |dy| for x and z
  logic                    d2_v;
  logic [1:0][PW-1:0]      d2_num, d2_quot;
  logic [S2_SIDE_W-1:0]    d2_side;
  logic [CW-1:0]           d2_x, d2_z;
  logic [QW-1:0]           d2_q;
  logic                    d2_dneg;

  assign d2_num[0] = m_rx_r;
  assign d2_num[1] = m_rz_r;

  psvp_div_pipe #(
    .NUM_W  (PW),
    .DEN_W  (DW),
    .LANES  (2),
    .SIDE_W (S2_SIDE_W)
  ) u_div_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_v_r),
    .in_num    (d2_num),
    .den       (dy_mag_r),
    .in_side   ({m_x_r, m_z_r, m_q_r, m_dneg_r}),
    .out_valid (d2_v),
    .out_quot  (d2_quot),
    .out_rem   (),
    .out_side  (d2_side)
  );

  assign {d2_x, d2_z, d2_q, d2_dneg} = d2_side;

  // tail 1: whole-quotient products
  logic          f1_v_r, f1_dneg_r;
  logic [TW-1:0] f1_tx_r, f1_tz_r, tx_full, tz_full;
  logic [DW-1:0] f1_ux_r, f1_uz_r;
  logic [CW-1:0] f1_x_r, f1_z_r;

  assign tx_full = d2_q * dx_mag_r;
  assign tz_full = d2_q * dz_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_tx_r   <= tx_full;
    f1_tz_r   <= tz_full;
    f1_ux_r   <= d2_quot[0][DW-1:0];
    f1_uz_r   <= d2_quot[1][DW-1:0];
    f1_x_r    <= d2_x;
    f1_z_r    <= d2_z;
    f1_dneg_r <= d2_dneg;
  end

  // tail 2: offset magnitudes
  logic          f2_v_r, f2_dneg_r;
  logic [TW-1:0] f2_sx_r, f2_sz_r;
  logic [CW-1:0] f2_x_r, f2_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f2_sx_r   <= f1_tx_r + TW'(f1_ux_r);
    f2_sz_r   <= f1_tz_r + TW'(f1_uz_r);
    f2_x_r    <= f1_x_r;
    f2_z_r    <= f1_z_r;
    f2_dneg_r <= f1_dneg_r;
  end

  // tail 3: projected coordinates
  logic          f3_v_r;
  logic [OW-1:0] f3_px_r, f3_pz_r;
  logic [OW-1:0] xe, ze, sxe, sze;
  logic          neg_x, neg_z;

  assign xe    = {{(OW-CW){f2_x_r[CW-1]}}, f2_x_r};
  assign ze    = {{(OW-CW){f2_z_r[CW-1]}}, f2_z_r};
  assign sxe   = {{(OW-TW){1'b0}}, f2_sx_r};
  assign sze   = {{(OW-TW){1'b0}}, f2_sz_r};
  assign neg_x = f2_dneg_r ^ dy_neg_r ^ dx_neg_r;
  assign neg_z = f2_dneg_r ^ dy_neg_r ^ dz_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_v_r <= 1'b0;
    end else begin
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f3_px_r <= neg_x ? (xe - sxe) : (xe + sxe);
    f3_pz_r <= neg_z ? (ze - sze) : (ze + sze);
  end

  // tail 4: widened box test
  logic          f4_v_r, f4_hit_r;
  logic [OW-1:0] f4_px_r, f4_pz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f4_v_r <= 1'b0;
    end else begin
      f4_v_r <= f3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f4_hit_r <= !dy_zero_r &&
                ($signed(f3_px_r) >= $signed(lo_x_r)) &&
                ($signed(f3_px_r) <= $signed(hi_x_r)) &&
                ($signed(f3_pz_r) >= $signed(lo_z_r)) &&
                ($signed(f3_pz_r) <= $signed(hi_z_r));
    f4_px_r  <= f3_px_r;
    f4_pz_r  <= f3_pz_r;
  end

  // output word
  logic              out_valid_r;
  psvp_pkg::shadow_t out_shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f4_hit_r) begin
      out_shadow_r.shadow_x    <= sat_coord(f4_px_r);
      out_shadow_r.shadow_y    <= lift_y_r;
      out_shadow_r.shadow_z    <= sat_coord(f4_pz_r);
      out_shadow_r.on_receiver <= 1'b1;
    end else begin
      out_shadow_r.shadow_x    <= '0;
      out_shadow_r.shadow_y    <= psvp_pkg::OFF_Y;
      out_shadow_r.shadow_z    <= '0;
      out_shadow_r.on_receiver <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_shadow = out_shadow_r;

endmodule

// ----- rtl/psvp_checker.sv -----
// Port-level checker for the planar shadow vertex projector, bound to the top level.
// Depends on psvp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psvp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input psvp_pkg::shadow_t out_shadow,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  localparam int LAT = psvp_pkg::LATENCY;

  `PSVP_ASSERT_IMP(a_off_word, out_valid && !out_shadow.on_receiver, out_shadow.shadow_x == '0 && out_shadow.shadow_z == '0 && out_shadow.shadow_y == psvp_pkg::OFF_Y, "off-receiver word is not canonical")

  `PSVP_ASSERT_IMP(a_no_extra, out_valid, $past(start && !busy, LAT), "result word without an accepted vertex")

  `PSVP_ASSERT_IMP(a_no_loss, start && !busy, ##LAT out_valid, "accepted vertex produced no result word")

  `PSVP_ASSERT_IMP(a_cfg_idle, cfg_valid && cfg_ready, !busy, "config write taken while busy")

endmodule

bind planar_shadow_vertex_projector psvp_checker u_psvp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_shadow (out_shadow),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// ----- sim/tb_planar_shadow_vertex_projector.sv -----
`timescale 1ns / 100ps
// Self-checking bench for planar_shadow_vertex_projector: directed and random vertices under
// changing light and receiver settings, each result word checked against a local projection.
// Depends on psvp_pkg and the projector RTL only.
module tb_planar_shadow_vertex_projector;
  import psvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 172;
  localparam int PAUSE_BURST = 40;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -(64'sd1 <<< (COORD_W - 1));
  localparam longint QUOT_CLAMP = 64'sd1 <<< 49;
  localparam longint SPREAD = 64'sd1 <<< 26;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  vertex_t in_vertex;
  logic out_valid;
  shadow_t out_shadow;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  longint receiver_cfg [8];
  shadow_t pending_shadows [$];
  int fail_count = 0;
  int idle_pct = 16;
  int quiet_cycles = 0;

  planar_shadow_vertex_projector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_vertex  (in_vertex),
    .out_valid  (out_valid),
    .out_shadow (out_shadow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint along_light(longint diff, longint num, longint den);
    longint q, r, aq, an;
    q = diff / den;
    r = diff % den;
    aq = (q < 0) ? -q : q;
    an = (num < 0) ? -num : num;
    if (an != 0 && aq != 0 && aq > QUOT_CLAMP / an)
      return ((q < 0) != (num < 0)) ? -QUOT_CLAMP : QUOT_CLAMP;
    return q * num + (r * num) / den;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI)
      return COORD_HI;
    if (v < COORD_LO)
      return COORD_LO;
    return v;
  endfunction

  function automatic shadow_t project_vertex(vertex_t v);
    longint x, y, z, h, diff, px, pz;
    logic hit;
    shadow_t s;
    x = v.vertex_x;
    y = v.vertex_y;
    z = v.vertex_z;
    h = receiver_cfg[REG_PLANE_H];
    hit = 1'b0;
    px = 0;
    pz = 0;
    if (receiver_cfg[REG_DIR_Y] != 0) begin
      diff = h - y;
      px = x + along_light(diff, receiver_cfg[REG_DIR_X], receiver_cfg[REG_DIR_Y]);
      pz = z + along_light(diff, receiver_cfg[REG_DIR_Z], receiver_cfg[REG_DIR_Y]);
      hit = px >= receiver_cfg[REG_BOX_MIN_X] - MARGIN &&
            px <= receiver_cfg[REG_BOX_MAX_X] + MARGIN &&
            pz >= receiver_cfg[REG_BOX_MIN_Z] - MARGIN &&
            pz <= receiver_cfg[REG_BOX_MAX_Z] + MARGIN;
    end
    if (hit) begin
      s.shadow_x = COORD_W'(clamp_coord(px));
      s.shadow_y = COORD_W'(clamp_coord(h + LIFT));
      s.shadow_z = COORD_W'(clamp_coord(pz));
    end else begin
      s.shadow_x = '0;
      s.shadow_y = OFF_Y;
      s.shadow_z = '0;
    end
    s.on_receiver = hit;
    return s;
  endfunction

  function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                      logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endfunction

  function automatic longint pick_between(longint lo, longint hi);
    longint t, r;
    if (hi < lo) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    r = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
    return lo + r % (hi - lo + 1);
  endfunction

  function automatic longint rand_dir();
    case ($urandom_range(9))
      0: return -65536;
      1: return 65536;
      2: return $urandom_range(1) ? 131071 : -131072;
      default: return pick_between(-65536, 65536);
    endcase
  endfunction

  function automatic vertex_t mk_vertex(longint x, longint y, longint z);
    vertex_t v;
    v.vertex_x = x[COORD_W-1:0];
    v.vertex_y = y[COORD_W-1:0];
    v.vertex_z = z[COORD_W-1:0];
    return v;
  endfunction

  // aim the projection near the receiver box so that hits and margin edges are common
  function automatic vertex_t aimed_vertex();
    longint h, diff, y, x, z, tx, tz;
    h = receiver_cfg[REG_PLANE_H];
    tx = pick_between(receiver_cfg[REG_BOX_MIN_X] - 2000, receiver_cfg[REG_BOX_MAX_X] + 2000);
    tz = pick_between(receiver_cfg[REG_BOX_MIN_Z] - 2000, receiver_cfg[REG_BOX_MAX_Z] + 2000);
    diff = pick_between(-(64'sd1 <<< 22), 64'sd1 <<< 22);
    y = clamp_coord(h - diff);
    x = tx;
    z = tz;
    if (receiver_cfg[REG_DIR_Y] != 0) begin
      x = tx - along_light(h - y, receiver_cfg[REG_DIR_X], receiver_cfg[REG_DIR_Y]);
      z = tz - along_light(h - y, receiver_cfg[REG_DIR_Z], receiver_cfg[REG_DIR_Y]);
    end
    return mk_vertex(clamp_coord(x), y, clamp_coord(z));
  endfunction

  always @(posedge clk) begin : check_results
    shadow_t want;
    if (rst_n && out_valid) begin
      if (pending_shadows.size() == 0) begin
        $error("result word with no vertex pending: %h", out_shadow);
        fail_count++;
      end else begin
        want = pending_shadows.pop_front();
        check_field("shadow_x", want.shadow_x, out_shadow.shadow_x);
        check_field("shadow_y", want.shadow_y, out_shadow.shadow_y);
        check_field("shadow_z", want.shadow_z, out_shadow.shadow_z);
        check_field("on_receiver", COORD_W'(want.on_receiver), COORD_W'(out_shadow.on_receiver));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_planar_shadow_vertex_projector: FAIL");
      $finish;
    end
  end

  task automatic send_vertex(vertex_t v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_vertex <= v;
    do @(posedge clk); while (busy);
    pending_shadows = {pending_shadows, project_vertex(v)};
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_shadows.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_DIR_Z)
      receiver_cfg[idx] = $signed(data[DIR_W-1:0]);
    else
      receiver_cfg[idx] = $signed(data[COORD_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_receiver(longint dx, longint dy, longint dz, longint h,
                              longint min_x, longint max_x, longint min_z, longint max_z);
    longint vals [8];
    logic [CFG_DATA_W-1:0] data;
    vals = '{dx, dy, dz, h, min_x, max_x, min_z, max_z};
    wait_results_drained();
    for (int i = 0; i < 8; i++) begin
      data = vals[i][CFG_DATA_W-1:0];
      // direction registers keep only their low bits; scramble the rest
      if (i <= REG_DIR_Z)
        data[CFG_DATA_W-1:DIR_W] = (CFG_DATA_W-DIR_W)'($urandom);
      write_reg(cfg_reg_t'(i), data);
    end
  endtask

  task automatic test_reset_state();
    send_vertex(mk_vertex(0, 5 <<< 16, 0));
    send_vertex(mk_vertex(MARGIN, -123, -MARGIN));
    send_vertex(mk_vertex(MARGIN + 1, 0, 0));
  endtask

  task automatic test_directed_cases();
    set_receiver(65536, 65536, -65536, COORD_HI, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
    send_vertex(mk_vertex(300, 0, 0));
    send_vertex(mk_vertex(COORD_LO, COORD_HI, COORD_HI));
    send_vertex(mk_vertex(COORD_HI, COORD_LO, COORD_LO));
    set_receiver(-65536, -65536, 65536, COORD_LO, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
    send_vertex(mk_vertex(-300, 0, 0));
    set_receiver(131071, -131072, 3, 0, -(1 <<< 20), 1 <<< 20, -(1 <<< 20), 1 <<< 20);
    send_vertex(mk_vertex(0, 7, 0));
    send_vertex(mk_vertex(0, -7, 0));
    send_vertex(mk_vertex(5, 1 <<< 16, -5));
    set_receiver(0, 0, 0, 0, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
    send_vertex(mk_vertex(0, 0, 0));
    send_vertex(mk_vertex(1, 2, 3));
    set_receiver(0, 65536, 0, 0, 5000, -5000, 0, 0);
    send_vertex(mk_vertex(0, 0, 0));
    send_vertex(mk_vertex(5000, 0, 0));
    set_receiver(0, 65536, 0, 0, 100, -100, 0, 0);
    send_vertex(mk_vertex(0, 0, 0));
    set_receiver(0, 65536, 0, 0, 0, 0, -1000, 1000);
    send_vertex(mk_vertex(0, 0, 1000 + MARGIN));
    send_vertex(mk_vertex(0, 0, 1001 + MARGIN));
    send_vertex(mk_vertex(0, 0, -1000 - MARGIN));
  endtask

  task automatic random_receiver(int phase);
    longint dx, dy, dz, h, cx, cz, wx, wz;
    dx = rand_dir();
    dy = rand_dir();
    dz = rand_dir();
    if ($urandom_range(9) == 0)
      dy = 0;
    h = pick_between(-SPREAD, SPREAD);
    cx = pick_between(-SPREAD, SPREAD);
    cz = pick_between(-SPREAD, SPREAD);
    wx = pick_between(0, 64'sd1 <<< 22);
    wz = pick_between(0, 64'sd1 <<< 22);
    case (phase)
      0: set_receiver(dx, dy, dz, COORD_HI, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
      1: set_receiver(dx, dy, dz, COORD_LO, COORD_LO, COORD_HI, COORD_LO, COORD_HI);
      2: set_receiver(dx, dy, dz, h, cx + wx + 1, cx - wx, cz - wz, cz + wz);
      3: set_receiver(dx, 0, dz, h, cx - wx, cx + wx, cz - wz, cz + wz);
      default: set_receiver(dx, dy, dz, h, cx - wx, cx + wx, cz - wz, cz + wz);
    endcase
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_receiver(phase);
      idle_pct = (phase == 5) ? 0 : 16;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 65)
          send_vertex(aimed_vertex());
        else
          send_vertex(mk_vertex($signed($urandom), $signed($urandom), $signed($urandom)));
      end
    end
    idle_pct = 16;
  endtask

  task automatic test_drain_pause();
    random_receiver(RANDOM_PHASES);
    idle_pct = 0;
    for (int n = 0; n < PAUSE_BURST; n++)
      send_vertex(aimed_vertex());
    wait_results_drained();
    for (int n = 0; n < PAUSE_BURST; n++)
      send_vertex(aimed_vertex());
    idle_pct = 16;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_vertex = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 8; i++)
      receiver_cfg[i] = 0;
    receiver_cfg[REG_DIR_Y] = 65536;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_cases();
    test_random_configs();
    test_drain_pause();
    wait_results_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("tb_planar_shadow_vertex_projector: PASS");
    else
      $display("tb_planar_shadow_vertex_projector: FAIL");
    $finish;
  end

endmodule
